FILE: design/multirotor_motor_mixer_macros.svh
// Assertion macros used by the motor mixer top level.
`ifndef MULTIROTOR_MOTOR_MIXER_MACROS_SVH
`define MULTIROTOR_MOTOR_MIXER_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define MMM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define MMM_ASSERT_NEXT(label, pre, post, msg) \
    `MMM_ASSERT(label, (pre) |=> (post), msg)

`endif

FILE: design/mmm_pkg.sv
// Types, constants and weight tables for the motor mixer.
`default_nettype none
package mmm_pkg;

    typedef enum logic [1:0] {
        REG_PULSE_MIN   = 2'd0,
        REG_PULSE_MAX   = 2'd1,
        REG_RUDDER_TRIM = 2'd2
    } cfg_reg_t;

    localparam logic [14:0] PULSE_MIN_RST   = 15'd2000;
    localparam logic [14:0] PULSE_MAX_RST   = 15'd4000;
    localparam logic [14:0] RUDDER_TRIM_RST = 15'd3000;
    localparam logic [14:0] PULSE_CEIL      = 15'h7fff;

    // Q15 weights: 0.866, 0.5, nearly one, minus one
    localparam logic signed [15:0] W866  = 16'sd28377;
    localparam logic signed [15:0] WHALF = 16'sd16384;
    localparam logic signed [15:0] WONE  = 16'sd32767;
    localparam logic signed [15:0] WNEG  = 16'sh8000;
    localparam logic signed [15:0] WZERO = 16'sd0;

    typedef struct packed {
        logic [14:0]        thr;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
    } cmd_t;

    typedef struct packed {
        logic [2:0] index;
        logic       tail;
        logic       last;
    } tag_t;

    function automatic logic signed [15:0] cos_weight(input logic [2:0] rotors,
                                                      input logic [2:0] idx);
        logic signed [15:0] w;
        w = WZERO;
        case (rotors)
            3'd3:
            begin
                case (idx)
                    3'd0: w = W866;
                    3'd2: w = -W866;
                    default: w = WZERO;
                endcase
            end
            3'd6:
            begin
                case (idx)
                    3'd1, 3'd2: w = W866;
                    3'd4, 3'd5: w = -W866;
                    default: w = WZERO;
                endcase
            end
            default:
            begin
                case (idx)
                    3'd1: w = WONE;
                    3'd3: w = WNEG;
                    default: w = WZERO;
                endcase
            end
        endcase
        return w;
    endfunction

    function automatic logic signed [15:0] sin_weight(input logic [2:0] rotors,
                                                      input logic [2:0] idx);
        logic signed [15:0] w;
        w = WZERO;
        case (rotors)
            3'd3:
            begin
                case (idx)
                    3'd0, 3'd2: w = WHALF;
                    3'd1: w = WNEG;
                    default: w = WZERO;
                endcase
            end
            3'd6:
            begin
                case (idx)
                    3'd0: w = WONE;
                    3'd1, 3'd5: w = WHALF;
                    3'd2, 3'd4: w = -WHALF;
                    3'd3: w = WNEG;
                    default: w = WZERO;
                endcase
            end
            default:
            begin
                case (idx)
                    3'd0: w = WONE;
                    3'd2: w = WNEG;
                    default: w = WZERO;
                endcase
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

FILE: design/multirotor_motor_mixer.sv
// Top level of the multirotor motor mixer.
// Each command accepted on the slave stream yields one pulse transaction per rotor on the
// master stream, in rotor order, with tlast on the final one; with three rotors a fourth
// transaction carries the tail servo pulse and tuser set. The sequencer issues one rotor
// slot per cycle while the output is not stalled, and the next command is taken in the
// cycle its final slot issues. Each result passes through a multiply stage, a mix stage,
// a clamp stage and the output register; backpressure freezes all stages together.
// Configuration writes take effect on the next edge and are meant for when the block is
// idle.
`default_nettype none
`include "multirotor_motor_mixer_macros.svh"
module multirotor_motor_mixer #(
    parameter int ROTOR_COUNT = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [14:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // throttle, roll_cmd, pitch_cmd, yaw_cmd, pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // motor_index, pulse, pad
    output logic             m_tuser,   // is_tail
    output logic             m_tlast
);

    localparam int         TOTAL    = (ROTOR_COUNT == 3) ? 4 : ROTOR_COUNT;
    localparam logic [2:0] LAST_IDX = 3'(TOTAL - 1);

    logic [14:0] pulse_min_reg, pulse_max_reg, rudder_trim_reg;
    logic        adv;

    mmm_pkg::cmd_t      in_cmd, seq_cmd;
    mmm_pkg::tag_t      seq_tag, mul_tag, mix_tag, out_tag;
    logic               seq_valid, mul_valid, mix_valid, out_valid;
    logic [2:0]         seq_idx;
    logic [14:0]        mul_thr, out_pulse;
    logic signed [15:0] mul_yaw;
    logic signed [31:0] mul_prod_c, mul_prod_s;
    logic signed [17:0] mix_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_min_reg   <= mmm_pkg::PULSE_MIN_RST;
            pulse_max_reg   <= mmm_pkg::PULSE_MAX_RST;
            rudder_trim_reg <= mmm_pkg::RUDDER_TRIM_RST;
        end
        else if (cfg_wr_en)
        begin
            case (mmm_pkg::cfg_reg_t'(cfg_index))
                mmm_pkg::REG_PULSE_MIN:   pulse_min_reg   <= cfg_data;
                mmm_pkg::REG_PULSE_MAX:   pulse_max_reg   <= cfg_data;
                mmm_pkg::REG_RUDDER_TRIM: rudder_trim_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // advance every stage unless the output holds an untaken transaction
    assign adv = !out_valid || m_tready;

    assign in_cmd.thr   = s_tdata[14:0];
    assign in_cmd.roll  = s_tdata[30:15];
    assign in_cmd.pitch = s_tdata[46:31];
    assign in_cmd.yaw   = s_tdata[62:47];

    mmm_seq #(.ROTOR_COUNT(ROTOR_COUNT)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (in_cmd),
        .out_valid (seq_valid),
        .out_cmd   (seq_cmd),
        .out_tag   (seq_tag),
        .idx       (seq_idx)
    );

    mmm_mult #(.ROTOR_COUNT(ROTOR_COUNT)) u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (seq_valid),
        .in_cmd     (seq_cmd),
        .in_tag     (seq_tag),
        .out_valid  (mul_valid),
        .out_tag    (mul_tag),
        .out_thr    (mul_thr),
        .out_yaw    (mul_yaw),
        .out_prod_c (mul_prod_c),
        .out_prod_s (mul_prod_s)
    );

    mmm_mix #(.ROTOR_COUNT(ROTOR_COUNT)) u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (mul_valid),
        .in_tag    (mul_tag),
        .in_thr    (mul_thr),
        .in_yaw    (mul_yaw),
        .in_prod_c (mul_prod_c),
        .in_prod_s (mul_prod_s),
        .out_valid (mix_valid),
        .out_tag   (mix_tag),
        .out_mix   (mix_val)
    );

    mmm_limit u_limit (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (mix_valid),
        .in_tag      (mix_tag),
        .in_mix      (mix_val),
        .pulse_min   (pulse_min_reg),
        .pulse_max   (pulse_max_reg),
        .rudder_trim (rudder_trim_reg),
        .out_valid   (out_valid),
        .out_tag     (out_tag),
        .out_pulse   (out_pulse)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {6'd0, out_pulse, out_tag.index};
    assign m_tuser  = out_tag.tail;
    assign m_tlast  = out_tag.last;

    `MMM_ASSERT_NEXT(a_accept_starts_rotor0, s_tvalid && s_tready, seq_valid && (seq_idx == 3'd0), "accepted command did not start at rotor zero")
    `MMM_ASSERT(a_slot_in_range, seq_valid |-> (seq_idx <= LAST_IDX), "rotor slot beyond the last one")
    `MMM_ASSERT(a_tail_is_last, (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata[2:0] == 3'd0)), "tail result not last or index not zero")

endmodule
`default_nettype wire

FILE: design/mmm_seq.sv
// Command register and rotor sequencer: issues one rotor slot per cycle while adv is high.
`default_nettype none
module mmm_seq #(
    parameter int ROTOR_COUNT = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire mmm_pkg::cmd_t in_cmd,
    output logic               out_valid,
    output mmm_pkg::cmd_t      out_cmd,
    output mmm_pkg::tag_t      out_tag,
    output logic [2:0]         idx
);

    localparam int         TOTAL    = (ROTOR_COUNT == 3) ? 4 : ROTOR_COUNT;
    localparam logic [2:0] LAST_IDX = 3'(TOTAL - 1);

    logic          busy_reg, busy_next;
    logic [2:0]    idx_reg, idx_next;
    mmm_pkg::cmd_t cmd_reg, cmd_next;
    logic          at_last;
    logic          accept;

    assign at_last  = (idx_reg == LAST_IDX);
    assign in_ready = adv && (!busy_reg || at_last);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        cmd_next  = cmd_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            idx_next  = 3'd0;
            cmd_next  = in_cmd;
        end
        else if (busy_reg && adv)
        begin
            if (at_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign out_valid     = busy_reg;
    assign out_cmd       = cmd_reg;
    assign out_tag.tail  = (ROTOR_COUNT == 3) && at_last;
    assign out_tag.index = out_tag.tail ? 3'd0 : idx_reg;
    assign out_tag.last  = at_last;
    assign idx           = idx_reg;

endmodule
`default_nettype wire

FILE: design/mmm_mult.sv
// Stage one: weight lookup and the two Q15 products.
`default_nettype none
module mmm_mult #(
    parameter int ROTOR_COUNT = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          in_valid,
    input  wire mmm_pkg::cmd_t in_cmd,
    input  wire mmm_pkg::tag_t in_tag,
    output logic               out_valid,
    output mmm_pkg::tag_t      out_tag,
    output logic [14:0]        out_thr,
    output logic signed [15:0] out_yaw,
    output logic signed [31:0] out_prod_c,
    output logic signed [31:0] out_prod_s
);

    logic                valid_reg;
    mmm_pkg::tag_t       tag_reg;
    logic [14:0]         thr_reg;
    logic signed [15:0]  yaw_reg;
    logic signed [31:0]  prod_c_reg, prod_c_next;
    logic signed [31:0]  prod_s_reg, prod_s_next;
    logic signed [15:0]  wc, ws;

    always_comb
    begin
        // tail slot carries no roll or pitch term
        if (in_tag.tail)
        begin
            wc = mmm_pkg::WZERO;
            ws = mmm_pkg::WZERO;
        end
        else
        begin
            wc = mmm_pkg::cos_weight(3'(ROTOR_COUNT), in_tag.index);
            ws = mmm_pkg::sin_weight(3'(ROTOR_COUNT), in_tag.index);
        end
        prod_c_next = wc * in_cmd.roll;
        prod_s_next = ws * in_cmd.pitch;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag_reg    <= in_tag;
            thr_reg    <= in_cmd.thr;
            yaw_reg    <= in_cmd.yaw;
            prod_c_reg <= prod_c_next;
            prod_s_reg <= prod_s_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_tag    = tag_reg;
    assign out_thr    = thr_reg;
    assign out_yaw    = yaw_reg;
    assign out_prod_c = prod_c_reg;
    assign out_prod_s = prod_s_reg;

endmodule
`default_nettype wire

FILE: design/mmm_mix.sv
// Stage two: sum products, take the Q15 high half, mix throttle and yaw.
`default_nettype none
module mmm_mix #(
    parameter int ROTOR_COUNT = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               adv,
    input  wire logic               in_valid,
    input  wire mmm_pkg::tag_t      in_tag,
    input  wire logic [14:0]        in_thr,
    input  wire logic signed [15:0] in_yaw,
    input  wire logic signed [31:0] in_prod_c,
    input  wire logic signed [31:0] in_prod_s,
    output logic                    out_valid,
    output mmm_pkg::tag_t           out_tag,
    output logic signed [17:0]      out_mix
);

    logic                valid_reg;
    mmm_pkg::tag_t       tag_reg;
    logic signed [17:0]  mix_reg, mix_next;
    logic [31:0]         acc;
    logic signed [17:0]  hi_x, thr_x, yaw_x, base;

    always_comb
    begin
        acc   = in_prod_c + in_prod_s;
        // bits 31..16 of the sum shifted left once
        hi_x  = {{2{acc[30]}}, acc[30:15]};
        thr_x = {3'b000, in_thr};
        yaw_x = {{2{in_yaw[15]}}, in_yaw};
        base  = thr_x - hi_x;
        if (in_tag.tail)
        begin
            mix_next = yaw_x;
        end
        else if (ROTOR_COUNT == 3)
        begin
            mix_next = base;
        end
        else if (in_tag.index[0])
        begin
            mix_next = base - yaw_x;
        end
        else
        begin
            mix_next = base + yaw_x;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag_reg <= in_tag;
            mix_reg <= mix_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_tag   = tag_reg;
    assign out_mix   = mix_reg;

endmodule
`default_nettype wire

FILE: design/mmm_limit.sv
// Stages three and four: clamp to the pulse window, add rudder trim to the tail pulse, output register.
`default_nettype none
module mmm_limit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               adv,
    input  wire logic               in_valid,
    input  wire mmm_pkg::tag_t      in_tag,
    input  wire logic signed [17:0] in_mix,
    input  wire logic [14:0]        pulse_min,
    input  wire logic [14:0]        pulse_max,
    input  wire logic [14:0]        rudder_trim,
    output logic                    out_valid,
    output mmm_pkg::tag_t           out_tag,
    output logic [14:0]             out_pulse
);

    logic               sat_valid_reg;
    mmm_pkg::tag_t      sat_tag_reg;
    logic [14:0]        sat_reg, sat_next;
    logic               out_valid_reg;
    mmm_pkg::tag_t      out_tag_reg;
    logic [14:0]        pulse_reg, pulse_next;
    logic signed [17:0] min_x, max_x, upper;
    logic [15:0]        tail_sum;

    always_comb
    begin
        min_x = {3'b000, pulse_min};
        max_x = {3'b000, pulse_max};
        // upper bound first, lower bound wins when the limits cross
        upper = (in_mix > max_x) ? max_x : in_mix;
        sat_next = (upper < min_x) ? pulse_min : upper[14:0];
    end

    always_comb
    begin
        tail_sum = {1'b0, rudder_trim} + {1'b0, sat_reg};
        if (sat_tag_reg.tail)
        begin
            pulse_next = tail_sum[15] ? mmm_pkg::PULSE_CEIL : tail_sum[14:0];
        end
        else
        begin
            pulse_next = sat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sat_valid_reg <= in_valid;
            out_valid_reg <= sat_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sat_tag_reg <= in_tag;
            sat_reg     <= sat_next;
            out_tag_reg <= sat_tag_reg;
            pulse_reg   <= pulse_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tag   = out_tag_reg;
    assign out_pulse = pulse_reg;

endmodule
`default_nettype wire

FILE: test/multirotor_motor_mixer_tb.sv
// Self-checking testbench for the multirotor motor mixer, with its own mixing predictor.
module multirotor_motor_mixer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROTOR_COUNT  = 4;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 40;
    localparam int PRINT_CAP    = 60;

    // Index outside the register map; the block must ignore writes to it.
    localparam logic [1:0] REG_SPARE = 2'd3;

    // Q15 weights used by the mixing predictor
    localparam int Q_866  = 28377;
    localparam int Q_HALF = 16384;
    localparam int Q_ONE  = 32767;
    localparam int Q_NEG  = -32768;

    typedef enum int { READY_ALWAYS, READY_RANDOM, READY_PATTERN } ready_mode_t;

    typedef struct {
        logic [2:0]  rotor;
        logic        tail;
        logic [14:0] pulse;
        logic        last;
    } pulse_result_t;

    class mixer_ledger #(int ROTORS = 4);
        pulse_result_t pulses_due[$];
        logic [14:0]   pulse_min;
        logic [14:0]   pulse_max;
        logic [14:0]   rudder_trim;
        int            cos_tab[6];
        int            sin_tab[6];
        int            errors;

        function new();
            pulse_min   = mmm_pkg::PULSE_MIN_RST;
            pulse_max   = mmm_pkg::PULSE_MAX_RST;
            rudder_trim = mmm_pkg::RUDDER_TRIM_RST;
            errors      = 0;
            foreach (cos_tab[i])
            begin
                cos_tab[i] = 0;
                sin_tab[i] = 0;
            end
            case (ROTORS)
                3:
                begin
                    cos_tab[0] = Q_866;  sin_tab[0] = Q_HALF;
                    cos_tab[1] = 0;      sin_tab[1] = Q_NEG;
                    cos_tab[2] = -Q_866; sin_tab[2] = Q_HALF;
                end
                6:
                begin
                    cos_tab[0] = 0;      sin_tab[0] = Q_ONE;
                    cos_tab[1] = Q_866;  sin_tab[1] = Q_HALF;
                    cos_tab[2] = Q_866;  sin_tab[2] = -Q_HALF;
                    cos_tab[3] = 0;      sin_tab[3] = Q_NEG;
                    cos_tab[4] = -Q_866; sin_tab[4] = -Q_HALF;
                    cos_tab[5] = -Q_866; sin_tab[5] = Q_HALF;
                end
                default:
                begin
                    // four rotors (and other counts): rotors beyond the fourth keep zero weights
                    cos_tab[0] = 0;      sin_tab[0] = Q_ONE;
                    cos_tab[1] = Q_ONE;  sin_tab[1] = 0;
                    cos_tab[2] = 0;      sin_tab[2] = Q_NEG;
                    cos_tab[3] = Q_NEG;  sin_tab[3] = 0;
                end
            endcase
        endfunction

        function void set_register(logic [1:0] idx, logic [14:0] value);
            case (idx)
                mmm_pkg::REG_PULSE_MIN:   pulse_min = value;
                mmm_pkg::REG_PULSE_MAX:   pulse_max = value;
                mmm_pkg::REG_RUDDER_TRIM: rudder_trim = value;
                default: ;
            endcase
        endfunction

        // Upper bound first, lower bound second: crossed limits give pulse_min.
        function int clamp_pulse(int v);
            if (v > int'(pulse_max))
                v = int'(pulse_max);
            if (v < int'(pulse_min))
                v = int'(pulse_min);
            return v;
        endfunction

        function void note_command(mmm_pkg::cmd_t c);
            int            thr;
            int            roll;
            int            pitch;
            int            yaw;
            int            total;
            int            hi;
            int            mixed;
            logic [31:0]   acc;
            pulse_result_t r;
            thr   = c.thr;
            roll  = c.roll;
            pitch = c.pitch;
            yaw   = c.yaw;
            total = (ROTORS == 3) ? 4 : ROTORS;
            for (int i = 0; i < ROTORS; i++)
            begin
                acc   = cos_tab[i] * roll + sin_tab[i] * pitch;
                acc   = acc << 1;
                hi    = $signed(acc[31:16]);
                mixed = thr - hi;
                if (ROTORS != 3)
                    mixed = (i % 2 == 1) ? mixed - yaw : mixed + yaw;
                mixed   = clamp_pulse(mixed);
                r.rotor = i[2:0];
                r.tail  = 1'b0;
                r.pulse = mixed[14:0];
                r.last  = (i + 1 == total);
                pulses_due.push_back(r);
            end
            if (ROTORS == 3)
            begin
                mixed = int'(rudder_trim) + clamp_pulse(yaw);
                if (mixed > 32767)
                    mixed = 32767;
                if (mixed < 0)
                    mixed = 0;
                r.rotor = 3'd0;
                r.tail  = 1'b1;
                r.pulse = mixed[14:0];
                r.last  = 1'b1;
                pulses_due.push_back(r);
            end
        endfunction

        function int pending();
            return pulses_due.size();
        endfunction

        task report(string what);
            if (errors < PRINT_CAP)
                $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic [2:0] rotor, logic tail, logic [14:0] pulse, logic last);
            pulse_result_t want;
            if (pulses_due.size() == 0)
            begin
                report($sformatf("unexpected result rotor=%0d tail=%0d pulse=%0d last=%0d",
                                 rotor, tail, pulse, last));
                return;
            end
            want = pulses_due.pop_front();
            if (rotor !== want.rotor)
                report($sformatf("motor_index %0d, want %0d", rotor, want.rotor));
            if (tail !== want.tail)
                report($sformatf("is_tail %0d, want %0d (rotor %0d)", tail, want.tail,
                                 want.rotor));
            if (pulse !== want.pulse)
                report($sformatf("pulse %0d, want %0d (rotor %0d)", pulse, want.pulse,
                                 want.rotor));
            if (last !== want.last)
                report($sformatf("last %0d, want %0d (rotor %0d)", last, want.last,
                                 want.rotor));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [14:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // throttle, roll_cmd, pitch_cmd, yaw_cmd, pad
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // motor_index, pulse, pad
    logic        m_tuser;   // is_tail
    logic        m_tlast;

    mixer_ledger #(ROTOR_COUNT) ledger;
    int          cycle_count;
    ready_mode_t ready_mode;
    int          ready_left;
    int          ready_tick;

    multirotor_motor_mixer #(.ROTOR_COUNT(ROTOR_COUNT)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: alternate between free flow, random stalls and a fixed stall pattern.
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 2));
            ready_left = $urandom_range(20, 120);
        end
        ready_left--;
        ready_tick++;
        case (ready_mode)
            READY_ALWAYS:  m_tready <= 1'b1;
            READY_RANDOM:  m_tready <= ($urandom_range(0, 2) != 0);
            default:       m_tready <= ((ready_tick % 7) < 4);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            ledger.check_result(m_tdata[2:0], m_tuser, m_tdata[17:3], m_tlast);
    end

    function automatic logic signed [15:0] extreme_word();
        case ($urandom_range(0, 4))
            0: return 16'sh8000;
            1: return -16'sd1;
            2: return 16'sd0;
            3: return 16'sd1;
            default: return 16'sh7fff;
        endcase
    endfunction

    function automatic mmm_pkg::cmd_t random_command();
        mmm_pkg::cmd_t c;
        case ($urandom_range(0, 3))
            0:
            begin
                c.thr   = 15'($urandom_range(0, 32767));
                c.roll  = 16'($urandom);
                c.pitch = 16'($urandom);
                c.yaw   = 16'($urandom);
            end
            3:
            begin
                c.thr   = ($urandom_range(0, 1) == 1) ? 15'h7fff : 15'd0;
                c.roll  = extreme_word();
                c.pitch = extreme_word();
                c.yaw   = extreme_word();
            end
            default:
            begin
                // keep mixes near the pulse window so few of them saturate
                c.thr   = 15'($urandom_range(0, 8000));
                c.roll  = 16'($urandom_range(0, 6000) - 3000);
                c.pitch = 16'($urandom_range(0, 6000) - 3000);
                c.yaw   = 16'($urandom_range(0, 6000) - 3000);
            end
        endcase
        return c;
    endfunction

    task automatic drive_command(input mmm_pkg::cmd_t c);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, c.yaw, c.pitch, c.roll, c.thr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        ledger.note_command(c);
    endtask

    task automatic directed_command(input int thr, input int roll, input int pitch,
                                    input int yaw);
        mmm_pkg::cmd_t c;
        c.thr   = 15'(thr);
        c.roll  = 16'(roll);
        c.pitch = 16'(pitch);
        c.yaw   = 16'(yaw);
        drive_command(c);
    endtask

    task automatic idle_input(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [14:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        ledger.set_register(idx, value);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic configure(input int lo, input int hi, input int trim);
        write_reg(mmm_pkg::REG_PULSE_MIN, lo[14:0]);
        write_reg(mmm_pkg::REG_PULSE_MAX, hi[14:0]);
        write_reg(mmm_pkg::REG_RUDDER_TRIM, trim[14:0]);
    endtask

    // Send commands in bursts of random length, usually separated by random gaps, then drain.
    task automatic run_burst_phase(input int count);
        int burst_left;
        burst_left = 0;
        for (int k = 0; k < count; k++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                if ($urandom_range(0, 3) != 0)
                    idle_input($urandom_range(1, 8));
            end
            drive_command(random_command());
            burst_left--;
        end
        idle_input(1);
        wait_drained();
    endtask

    initial
    begin
        int lo;
        ledger      = new();
        cycle_count = 0;
        ready_mode  = READY_ALWAYS;
        ready_left  = 0;
        ready_tick  = 0;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = mmm_pkg::REG_PULSE_MIN;
        cfg_data    = 15'd0;
        s_tvalid    = 1'b0;
        s_tdata     = 64'd0;
        m_tready    = 1'b0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed commands under the reset limits.
        directed_command(0, 0, 0, 0);
        directed_command(32767, 0, 0, 0);
        directed_command(3000, 1000, -1000, 500);
        directed_command(3000, 1, -1, 1);
        directed_command(3000, 32767, 0, 0);
        directed_command(3000, -32768, 0, 0);
        directed_command(3000, 0, 32767, 0);
        directed_command(3000, 0, -32768, 0);
        directed_command(3000, 0, 0, 32767);
        directed_command(3000, 0, 0, -32768);
        directed_command(32767, -32768, -32768, -32768);
        directed_command(0, 32767, 32767, 32767);
        directed_command(3000, -32768, 32767, 0);
        directed_command(3000, 32767, -32768, -1);
        idle_input(1);
        wait_drained();

        // A write to an unmapped index must leave the limits alone.
        write_reg(REG_SPARE, 15'h7fff);
        directed_command(2500, 400, -400, 800);
        directed_command(5000, -600, 300, -2500);
        idle_input(1);
        wait_drained();

        configure(0, 32767, 0);
        run_burst_phase(PHASE_ITEMS);
        configure(0, 32767, 32767);
        run_burst_phase(PHASE_ITEMS);
        configure(1000, 1000, 16384);
        run_burst_phase(PHASE_ITEMS);
        // crossed limits
        configure(5000, 1500, 100);
        run_burst_phase(PHASE_ITEMS);
        configure(32767, 0, 32767);
        run_burst_phase(PHASE_ITEMS);
        repeat (3)
        begin
            lo = $urandom_range(0, 6000);
            configure(lo, lo + $urandom_range(0, 26000), $urandom_range(0, 32767));
            run_burst_phase(PHASE_ITEMS);
        end
        configure(mmm_pkg::PULSE_MIN_RST, mmm_pkg::PULSE_MAX_RST, mmm_pkg::RUDDER_TRIM_RST);
        run_burst_phase(PHASE_ITEMS);

        if (ledger.errors == 0 && ledger.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+design
design/mmm_pkg.sv
design/mmm_seq.sv
design/mmm_mult.sv
design/mmm_mix.sv
design/mmm_limit.sv
design/multirotor_motor_mixer.sv
test/multirotor_motor_mixer_tb.sv
